[src/fcspm_pkg.sv]
// Shared types and constants for the four-channel stereo pan mixer.
// Used by the lane, merge and top-level modules; depends on nothing else.

package fcspm_pkg;

   localparam int NumChannels = 4;
   localparam int SampleWidth = 24;
   localparam int RegWidth    = 17;
   localparam int GainWidth   = 33;
   localparam int ProductWidth = 57;
   localparam int AccWidth    = 59;
   localparam int OutWidth    = 26;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef logic signed [SampleWidth-1:0]  sample_type;
   typedef logic        [RegWidth-1:0]     reg_type;
   typedef logic        [GainWidth-1:0]    gain_type;
   typedef logic signed [ProductWidth-1:0] product_type;
   typedef logic signed [AccWidth-1:0]     acc_type;
   typedef logic signed [OutWidth-1:0]     out_type;

   localparam reg_type UnityQ16  = 17'd65536;
   localparam reg_type CentreQ16 = 17'd32768;

   // Half an output LSB in the Q32 accumulator.
   localparam acc_type RoundBias = 59'sd2147483648;

   typedef enum logic [2:0] {
      CSR_LEVEL_CH1 = 3'd0,
      CSR_LEVEL_CH2 = 3'd1,
      CSR_LEVEL_CH3 = 3'd2,
      CSR_LEVEL_CH4 = 3'd3,
      CSR_PAN_CH1   = 3'd4,
      CSR_PAN_CH2   = 3'd5,
      CSR_PAN_CH3   = 3'd6,
      CSR_PAN_CH4   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
   } lane_ctrl_type;

   typedef struct packed {
      logic s4_load;
      logic s5_load;
   } merge_ctrl_type;

   typedef struct packed {
      product_type left;
      product_type right;
   } lane_result_type;

endpackage

[src/fcspm_lane.sv]
// One mixer channel lane: pan law, gain multiply and sample-by-gain products.
// Depends on fcspm_pkg.

module fcspm_lane (
   input  logic                      clock,
   input  fcspm_pkg::reg_type         level,
   input  fcspm_pkg::reg_type         pan,
   input  fcspm_pkg::sample_type      left_in,
   input  fcspm_pkg::sample_type      right_in,
   input  logic                      patched,
   input  fcspm_pkg::lane_ctrl_type   ctrl,
   output fcspm_pkg::lane_result_type result
);

   fcspm_pkg::reg_type    lvl_clamp;
   fcspm_pkg::reg_type    pan_clamp;
   fcspm_pkg::reg_type    pan_dist;
   fcspm_pkg::reg_type    pf_left;
   fcspm_pkg::reg_type    pf_right;
   logic [33:0]          gain_left_full;
   logic [33:0]          gain_right_full;

   fcspm_pkg::gain_type   gain_left_ff;
   fcspm_pkg::gain_type   gain_right_ff;
   fcspm_pkg::sample_type samp_left_ff;
   fcspm_pkg::sample_type samp_right_ff;
   fcspm_pkg::sample_type samp_right_in;

   logic signed [41:0]   hi_left_in;
   logic signed [41:0]   hi_right_in;
   logic signed [40:0]   lo_left_in;
   logic signed [40:0]   lo_right_in;
   logic signed [41:0]   hi_left_ff;
   logic signed [41:0]   hi_right_ff;
   logic signed [40:0]   lo_left_ff;
   logic signed [40:0]   lo_right_ff;

   fcspm_pkg::product_type prod_left_in;
   fcspm_pkg::product_type prod_right_in;
   fcspm_pkg::product_type prod_left_ff;
   fcspm_pkg::product_type prod_right_ff;

   // Registers above unity behave as unity.
   assign lvl_clamp = (level > fcspm_pkg::UnityQ16) ? fcspm_pkg::UnityQ16 : level;
   assign pan_clamp = (pan > fcspm_pkg::UnityQ16) ? fcspm_pkg::UnityQ16 : pan;
   assign pan_dist  = fcspm_pkg::UnityQ16 - pan_clamp;

   // Linear pan law: the far side falls to zero, the near side keeps the level.
   always_comb begin
      if (pan_clamp >= fcspm_pkg::CentreQ16) begin
         pf_left  = {pan_dist[15:0], 1'b0};
         pf_right = fcspm_pkg::UnityQ16;
      end else begin
         pf_left  = fcspm_pkg::UnityQ16;
         pf_right = {pan_clamp[15:0], 1'b0};
      end
   end

   assign gain_left_full  = lvl_clamp * pf_left;
   assign gain_right_full = lvl_clamp * pf_right;

   // An unpatched right input follows the left sample.
   assign samp_right_in = patched ? right_in : left_in;

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         gain_left_ff  <= gain_left_full[32:0];
         gain_right_ff <= gain_right_full[32:0];
         samp_left_ff  <= left_in;
         samp_right_ff <= samp_right_in;
      end
   end

   // The 33-bit gain is split into a high and a low half for the products.
   assign hi_left_in  = samp_left_ff  * $signed({1'b0, gain_left_ff[32:16]});
   assign lo_left_in  = samp_left_ff  * $signed({1'b0, gain_left_ff[15:0]});
   assign hi_right_in = samp_right_ff * $signed({1'b0, gain_right_ff[32:16]});
   assign lo_right_in = samp_right_ff * $signed({1'b0, gain_right_ff[15:0]});

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         hi_left_ff  <= hi_left_in;
         lo_left_ff  <= lo_left_in;
         hi_right_ff <= hi_right_in;
         lo_right_ff <= lo_right_in;
      end
   end

   assign prod_left_in  = $signed({hi_left_ff[40:0], 16'b0}) + 57'(lo_left_ff);
   assign prod_right_in = $signed({hi_right_ff[40:0], 16'b0}) + 57'(lo_right_ff);

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         prod_left_ff  <= prod_left_in;
         prod_right_ff <= prod_right_in;
      end
   end

   assign result.left  = prod_left_ff;
   assign result.right = prod_right_ff;

endmodule

[src/fcspm_merge.sv]
// Merging stage: sums the four lane products per side and rounds to 26 bits.
// Depends on fcspm_pkg.

module fcspm_merge (
   input  logic                       clock,
   input  fcspm_pkg::merge_ctrl_type   ctrl,
   input  fcspm_pkg::lane_result_type  lanes [fcspm_pkg::NumChannels],
   output fcspm_pkg::out_type          left_out,
   output fcspm_pkg::out_type          right_out
);

   fcspm_pkg::acc_type pair_left_in  [2];
   fcspm_pkg::acc_type pair_right_in [2];
   fcspm_pkg::acc_type pair_left_ff  [2];
   fcspm_pkg::acc_type pair_right_ff [2];
   fcspm_pkg::acc_type total_left;
   fcspm_pkg::acc_type total_right;
   fcspm_pkg::out_type left_out_ff;
   fcspm_pkg::out_type right_out_ff;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         pair_left_in[p]  = 59'(lanes[2*p].left)  + 59'(lanes[2*p+1].left);
         pair_right_in[p] = 59'(lanes[2*p].right) + 59'(lanes[2*p+1].right);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s4_load) begin
         pair_left_ff  <= pair_left_in;
         pair_right_ff <= pair_right_in;
      end
   end

   // Round half up: add half an LSB, then keep bits 57:32 of the Q32 sum.
   assign total_left  = pair_left_ff[0]  + pair_left_ff[1]  + fcspm_pkg::RoundBias;
   assign total_right = pair_right_ff[0] + pair_right_ff[1] + fcspm_pkg::RoundBias;

   always_ff @(posedge clock) begin
      if (ctrl.s5_load) begin
         left_out_ff  <= total_left[57:32];
         right_out_ff <= total_right[57:32];
      end
   end

   assign left_out  = left_out_ff;
   assign right_out = right_out_ff;

endmodule

[src/four_channel_stereo_pan_mixer_top.sv]
// Top level of the four-channel stereo pan mixer: register file, stage control,
// four channel lanes and the merging stage. Depends on fcspm_pkg, fcspm_lane, fcspm_merge.

// The mixer takes one voice per beat on the req_ channel (the left and right samples
// of four channels, a right-patched mask and a bypass flag) and returns one beat on
// the rsp_ channel holding the left and right mix. It sustains one beat per clock
// cycle as long as rsp_ready is high. A request passes five register stages, the first
// of which loads at the edge that accepts it; the last one drives rsp_: four lanes,
// one per channel, each spend three stages (gain multiply, split sample-by-gain
// products, product recombination), and the merging stage spends two (pairwise sums,
// final sum with rounding into the response register). Every stage has its own valid
// bit, so the pipeline keeps accepting requests into empty stages while a finished
// response waits on rsp_ready. Levels and pans are set through the csr_ port, one
// 17-bit register per word at byte address 4*i: levels of channels one to four, then
// pans of channels one to four. Write them only while the mixer holds no beat in
// flight. Bypass forces both outputs to zero.

module four_channel_stereo_pan_mixer_top (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  fcspm_pkg::sample_type  req_ch1_left,
   input  fcspm_pkg::sample_type  req_ch1_right,
   input  fcspm_pkg::sample_type  req_ch2_left,
   input  fcspm_pkg::sample_type  req_ch2_right,
   input  fcspm_pkg::sample_type  req_ch3_left,
   input  fcspm_pkg::sample_type  req_ch3_right,
   input  fcspm_pkg::sample_type  req_ch4_left,
   input  fcspm_pkg::sample_type  req_ch4_right,
   input  logic [3:0]             req_right_patched,
   input  logic                   req_bypass,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fcspm_pkg::out_type     rsp_left_out,
   output fcspm_pkg::out_type     rsp_right_out,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [fcspm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [fcspm_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [fcspm_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int NumStages = 5;

   fcspm_pkg::reg_type level_ff [fcspm_pkg::NumChannels];
   fcspm_pkg::reg_type pan_ff   [fcspm_pkg::NumChannels];
   fcspm_pkg::reg_type csr_read_value;
   fcspm_pkg::csr_index_type csr_index;
   logic csr_write;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] load;

   fcspm_pkg::lane_ctrl_type   lane_ctrl;
   fcspm_pkg::merge_ctrl_type  merge_ctrl;
   fcspm_pkg::sample_type      lane_left  [fcspm_pkg::NumChannels];
   fcspm_pkg::sample_type      lane_right [fcspm_pkg::NumChannels];
   fcspm_pkg::lane_result_type lane_result [fcspm_pkg::NumChannels];

   // ---------------------------------------------------------------------------
   // Configuration registers. Every word address maps onto one of the eight
   // registers through bits 4:2; only the low 17 data bits are kept.
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = fcspm_pkg::csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < fcspm_pkg::NumChannels; c++) begin
            level_ff[c] <= fcspm_pkg::UnityQ16;
            pan_ff[c]   <= fcspm_pkg::CentreQ16;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            fcspm_pkg::CSR_LEVEL_CH1: level_ff[0] <= csr_pwdata[16:0];
            fcspm_pkg::CSR_LEVEL_CH2: level_ff[1] <= csr_pwdata[16:0];
            fcspm_pkg::CSR_LEVEL_CH3: level_ff[2] <= csr_pwdata[16:0];
            fcspm_pkg::CSR_LEVEL_CH4: level_ff[3] <= csr_pwdata[16:0];
            fcspm_pkg::CSR_PAN_CH1:   pan_ff[0]   <= csr_pwdata[16:0];
            fcspm_pkg::CSR_PAN_CH2:   pan_ff[1]   <= csr_pwdata[16:0];
            fcspm_pkg::CSR_PAN_CH3:   pan_ff[2]   <= csr_pwdata[16:0];
            fcspm_pkg::CSR_PAN_CH4:   pan_ff[3]   <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         fcspm_pkg::CSR_LEVEL_CH1: csr_read_value = level_ff[0];
         fcspm_pkg::CSR_LEVEL_CH2: csr_read_value = level_ff[1];
         fcspm_pkg::CSR_LEVEL_CH3: csr_read_value = level_ff[2];
         fcspm_pkg::CSR_LEVEL_CH4: csr_read_value = level_ff[3];
         fcspm_pkg::CSR_PAN_CH1:   csr_read_value = pan_ff[0];
         fcspm_pkg::CSR_PAN_CH2:   csr_read_value = pan_ff[1];
         fcspm_pkg::CSR_PAN_CH3:   csr_read_value = pan_ff[2];
         fcspm_pkg::CSR_PAN_CH4:   csr_read_value = pan_ff[3];
         default:                  csr_read_value = '0;
      endcase
   end

   assign csr_prdata = 32'(csr_read_value);

   // ---------------------------------------------------------------------------
   // Stage control. A stage loads when it is empty or when the stage after it
   // loads; the last stage is the response register and drains on rsp_ready.
   // ---------------------------------------------------------------------------
   always_comb begin
      load[NumStages-1] = ~valid_ff[NumStages-1] | rsp_ready;
      for (int s = NumStages - 2; s >= 0; s--) begin
         load[s] = ~valid_ff[s] | load[s+1];
      end
      valid_in = valid_ff;
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int s = 1; s < NumStages; s++) begin
         if (load[s]) begin
            valid_in[s] = valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[NumStages-1];

   assign lane_ctrl.s1_load  = load[0];
   assign lane_ctrl.s2_load  = load[1];
   assign lane_ctrl.s3_load  = load[2];
   assign merge_ctrl.s4_load = load[3];
   assign merge_ctrl.s5_load = load[4];

   // ---------------------------------------------------------------------------
   // Lanes. Bypass feeds zero samples, which makes every product and so both
   // rounded sums exactly zero.
   // ---------------------------------------------------------------------------
   always_comb begin
      lane_left[0]  = req_ch1_left;
      lane_right[0] = req_ch1_right;
      lane_left[1]  = req_ch2_left;
      lane_right[1] = req_ch2_right;
      lane_left[2]  = req_ch3_left;
      lane_right[2] = req_ch3_right;
      lane_left[3]  = req_ch4_left;
      lane_right[3] = req_ch4_right;
      if (req_bypass) begin
         for (int c = 0; c < fcspm_pkg::NumChannels; c++) begin
            lane_left[c]  = '0;
            lane_right[c] = '0;
         end
      end
   end

   for (genvar c = 0; c < fcspm_pkg::NumChannels; c++) begin : g_lane
      fcspm_lane u_lane (
         .clock    (clock),
         .level    (level_ff[c]),
         .pan      (pan_ff[c]),
         .left_in  (lane_left[c]),
         .right_in (lane_right[c]),
         .patched  (req_right_patched[c]),
         .ctrl     (lane_ctrl),
         .result   (lane_result[c])
      );
   end

   fcspm_merge u_merge (
      .clock     (clock),
      .ctrl      (merge_ctrl),
      .lanes     (lane_result),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out)
   );

endmodule
